FILE: src/psw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types and constants of the pausable, seekable stopwatch.
// ----------------------------------------------------------------------------
package psw_pkg;

   localparam int TICK_W   = 64;
   localparam int CMD_W    = 3;
   localparam int REQ_DW   = 4 * TICK_W;
   localparam int RSP_BITS = 3 * TICK_W + 3;
   localparam int RSP_DW   = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD  = RSP_DW - RSP_BITS;

   typedef logic [TICK_W-1:0] tick_type;

   // Command codes; the remaining code is a plain query.
   typedef enum logic [CMD_W-1:0] {
      CMD_RESET     = 3'd0,
      CMD_START     = 3'd1,
      CMD_PAUSE     = 3'd2,
      CMD_RESUME    = 3'd3,
      CMD_SET       = 3'd4,
      CMD_SEEK_FWD  = 3'd5,
      CMD_SEEK_BACK = 3'd6
   } cmd_type;

   // One accepted command beat.
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      tick_type         now;
      tick_type         amount;
      tick_type         win_start;
      tick_type         win_end;
   } item_type;

   // State after a command, together with what the window check needs.
   typedef struct packed {
      logic     running;
      logic     frozen;
      tick_type base;
      tick_type pause_stamp;
      tick_type now;
      tick_type win_start;
      tick_type win_end;
   } snap_type;

   // Elapsed time after a command.
   typedef struct packed {
      logic     running;
      logic     frozen;
      tick_type elapsed;
      tick_type win_start;
      tick_type win_end;
   } elap_type;

   // Result beat, laid out exactly as rsp_tdata.
   typedef struct packed {
      logic [RSP_PAD-1:0]     pad;
      logic signed [TICK_W-1:0] outside_distance;
      tick_type               window_offset;
      logic                   in_window;
      logic                   is_frozen;
      logic                   is_running;
      tick_type               elapsed;
   } rsp_type;

endpackage

FILE: src/psw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_core
// Stopwatch state and command decode. The state is held as the sum of the
// start stamp and paused time, and a base equal to that sum minus the seek
// offset, so that elapsed time is a single subtraction from the stamp.
// ----------------------------------------------------------------------------
module psw_core import psw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     item_valid,
   input  item_type item,
   output logic     snap_valid,
   output snap_type snap
);

   tick_type s_ff, s_in;
   tick_type base_ff, base_in;
   tick_type pause_ff, pause_in;
   logic     running_ff, running_in;
   logic     frozen_ff, frozen_in;
   logic     snap_valid_ff;
   snap_type snap_ff;

   tick_type stamp;
   tick_type cur_elapsed;
   tick_type back_step;
   tick_type pause_gap;
   cmd_type  cmd;

   assign cmd = cmd_type'(item.cmd);

   // Elapsed time before the command, used by a backward seek.
   assign stamp       = frozen_ff ? pause_ff : item.now;
   assign cur_elapsed = running_ff ? (stamp - base_ff) : '0;
   assign back_step   = (cur_elapsed < item.amount) ? cur_elapsed : item.amount;
   assign pause_gap   = item.now - pause_ff;

   // Next state for each command.
   always_comb begin
      s_in       = s_ff;
      base_in    = base_ff;
      pause_in   = pause_ff;
      running_in = running_ff;
      frozen_in  = frozen_ff;
      unique case (cmd)
         CMD_RESET: begin
            s_in       = '0;
            base_in    = '0;
            pause_in   = '0;
            running_in = 1'b0;
            frozen_in  = 1'b0;
         end
         CMD_START: begin
            s_in       = item.now;
            base_in    = item.now;
            pause_in   = '0;
            running_in = 1'b1;
            frozen_in  = 1'b0;
         end
         CMD_PAUSE: begin
            if (running_ff && !frozen_ff) begin
               pause_in  = item.now;
               frozen_in = 1'b1;
            end
         end
         CMD_RESUME: begin
            if (running_ff && frozen_ff) begin
               s_in      = s_ff + pause_gap;
               base_in   = base_ff + pause_gap;
               pause_in  = '0;
               frozen_in = 1'b0;
            end
         end
         CMD_SET: begin
            if (running_ff && frozen_ff) begin
               // Freeze the stamp where elapsed reads exactly the amount.
               pause_in = s_ff;
               base_in  = s_ff - item.amount;
            end else begin
               s_in       = item.now;
               base_in    = item.now - item.amount;
               running_in = 1'b1;
               if (!running_ff) begin
                  pause_in  = '0;
                  frozen_in = 1'b0;
               end
            end
         end
         CMD_SEEK_FWD: begin
            base_in = base_ff - item.amount;
         end
         CMD_SEEK_BACK: begin
            base_in = base_ff + back_step;
         end
         default: begin
         end
      endcase
   end

   // State registers change only when a command beat moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff       <= '0;
         base_ff    <= '0;
         pause_ff   <= '0;
         running_ff <= 1'b0;
         frozen_ff  <= 1'b0;
      end else if (advance && item_valid) begin
         s_ff       <= s_in;
         base_ff    <= base_in;
         pause_ff   <= pause_in;
         running_ff <= running_in;
         frozen_ff  <= frozen_in;
      end
   end

   // Snapshot stage valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (advance) begin
         snap_valid_ff <= item_valid;
      end
   end

   // Snapshot payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         snap_ff.running     <= running_in;
         snap_ff.frozen      <= frozen_in;
         snap_ff.base        <= base_in;
         snap_ff.pause_stamp <= pause_in;
         snap_ff.now         <= item.now;
         snap_ff.win_start   <= item.win_start;
         snap_ff.win_end     <= item.win_end;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

FILE: src/psw_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_window
// Elapsed time from the state snapshot, then the event-window check into
// the result register.
// ----------------------------------------------------------------------------
module psw_window import psw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     snap_valid,
   input  snap_type snap,
   output logic     rsp_valid,
   output rsp_type  rsp
);

   elap_type elap_ff;
   logic     elap_valid_ff;
   rsp_type  rsp_ff, rsp_in;
   logic     rsp_valid_ff;

   tick_type stamp;
   tick_type to_start;
   tick_type to_end;
   logic     before_start;
   logic     after_end;

   assign stamp = snap.frozen ? snap.pause_stamp : snap.now;

   // Elapsed stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         elap_ff.running   <= snap.running;
         elap_ff.frozen    <= snap.frozen;
         elap_ff.elapsed   <= snap.running ? (stamp - snap.base) : '0;
         elap_ff.win_start <= snap.win_start;
         elap_ff.win_end   <= snap.win_end;
      end
   end

   // Window check: the before-start test wins over the after-end test.
   assign to_start     = elap_ff.elapsed - elap_ff.win_start;
   assign to_end       = elap_ff.elapsed - elap_ff.win_end;
   assign before_start = elap_ff.elapsed < elap_ff.win_start;
   assign after_end    = elap_ff.elapsed > elap_ff.win_end;

   always_comb begin
      rsp_in                  = '0;
      rsp_in.elapsed          = elap_ff.elapsed;
      rsp_in.is_running       = elap_ff.running;
      rsp_in.is_frozen        = elap_ff.frozen;
      if (before_start) begin
         rsp_in.outside_distance = $signed(to_start);
      end else if (after_end) begin
         rsp_in.outside_distance = $signed(to_end);
      end else begin
         rsp_in.in_window     = 1'b1;
         rsp_in.window_offset = to_start;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Valid bits of the elapsed and result stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         elap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         elap_valid_ff <= snap_valid;
         rsp_valid_ff  <= elap_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: src/pausable_seekable_stopwatch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pausable_seekable_stopwatch
// Stopwatch with pause, resume, set and seek commands and an event-window
// check on the elapsed time after every command.
// ----------------------------------------------------------------------------
//  channel   direction  ports                 beat
//  req       in         req_tvalid/tready     one command with its tick stamp
//  rsp       out        rsp_tvalid/tready     elapsed time and window check
//
//  One command per cycle while no result stalls; each result beat is offered
//  once its command beat has passed the input, state and elapsed registers
//  into the result register. The state update for one command is computed
//  combinationally, so commands follow each other with no gap.
//  Synchronous reset clears the stopwatch state and all stage valid bits.
//  A stalled result holds the whole pipeline; req_tready is high whenever the
//  result register is empty or being taken.
// ----------------------------------------------------------------------------
module pausable_seekable_stopwatch import psw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // Command channel.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,  // now_ticks, amount, window_start, window_end
   input  logic [CMD_W-1:0]  req_tuser,  // command
   // Result channel.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata   // elapsed, is_running, is_frozen, in_window,
                                         // window_offset, outside_distance, zero fill
);

   logic     advance;
   logic     item_valid_ff;
   item_type item_ff;
   logic     snap_valid;
   snap_type snap;
   logic     rsp_valid;
   rsp_type  rsp;

   // Every stage moves when the result register can take a new beat.
   assign advance    = !rsp_valid || rsp_tready;
   assign req_tready = advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (advance) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff.cmd       <= req_tuser;
         item_ff.now       <= req_tdata[TICK_W-1:0];
         item_ff.amount    <= req_tdata[2*TICK_W-1:TICK_W];
         item_ff.win_start <= req_tdata[3*TICK_W-1:2*TICK_W];
         item_ff.win_end   <= req_tdata[4*TICK_W-1:3*TICK_W];
      end
   end

   psw_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   psw_window u_window (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .snap_valid (snap_valid),
      .snap       (snap),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = rsp;

endmodule

FILE: src/psw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_checker
// Port-level checks of the stopwatch, bound to the top level.
// ----------------------------------------------------------------------------
module psw_checker import psw_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata
);

   rsp_type rsp;
   assign rsp = rsp_tdata;

   // A stalled result beat holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // The block takes commands whenever no result waits.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("command refused with empty result register");

   // A stopped stopwatch reads zero and is never frozen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.is_running |-> rsp.elapsed == '0 && !rsp.is_frozen)
      else $error("stopped stopwatch shows time or pause");

   // Window offset and outside distance are never both in use.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.in_window && rsp.outside_distance == '0) ||
                     (!rsp.in_window && rsp.window_offset == '0))
      else $error("window result fields disagree");

endmodule

bind pausable_seekable_stopwatch psw_checker u_psw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: sim/pausable_seekable_stopwatch_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pausable_seekable_stopwatch_tb
// Self-checking bench for the pausable, seekable stopwatch. A short table of
// directed commands covers reset, the field extremes, every command and the
// corner cases. It is followed by random command sequences that run along a
// moving tick stamp, with event windows placed around the current elapsed
// time. Every result beat is checked field by field against a predictor of
// the stopwatch state or a hand-typed result. Both sides stall at random.
// ----------------------------------------------------------------------------
module pausable_seekable_stopwatch_tb;
   import psw_pkg::*;

   localparam int DIR_ROWS     = 21;
   localparam int RAND_ITEMS   = 1500;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;

   // The one command code that the package leaves unnamed reads as a query.
   localparam logic [CMD_W-1:0] CMD_QUERY = 3'd7;
   localparam tick_type         TICK_MAX  = '1;

   // One command beat, with a result typed in by hand where it is obvious.
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      tick_type         now;
      tick_type         amount;
      tick_type         win_start;
      tick_type         win_end;
      bit               typed;
      rsp_type          want;
   } cmd_row_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]  req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;

   // Predicted stopwatch state.
   tick_type watch_start;
   tick_type watch_pause;
   tick_type watch_paused;
   tick_type watch_seek;
   bit       watch_running;
   bit       watch_frozen;

   rsp_type     pending_readings [$];
   cmd_row_type plan [DIR_ROWS];

   int  err_count       = 0;
   int  cmds_sent       = 0;
   int  results_checked = 0;
   int  window_hits     = 0;
   int  idle_cycles     = 0;
   int  stall_left      = 0;
   bit  calm            = 1'b0;

   pausable_seekable_stopwatch uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic tick_type rand_tick();
      return {$urandom, $urandom};
   endfunction

   function automatic void clear_watch();
      watch_start   = '0;
      watch_pause   = '0;
      watch_paused  = '0;
      watch_seek    = '0;
      watch_running = 1'b0;
      watch_frozen  = 1'b0;
   endfunction

   // Elapsed time at a given stamp; a frozen watch reads its pause stamp.
   function automatic tick_type watch_elapsed(tick_type now);
      if (!watch_running)
         return '0;
      return ((watch_frozen ? watch_pause : now) - watch_start - watch_paused) + watch_seek;
   endfunction

   // Applies one command to the predicted state and returns the reading.
   function automatic rsp_type advance_watch(logic [CMD_W-1:0] cmd, tick_type now,
                                             tick_type amount, tick_type ws,
                                             tick_type we);
      tick_type e;
      rsp_type  r;
      case (cmd)
         CMD_RESET: clear_watch();
         CMD_START: begin
            clear_watch();
            watch_start   = now;
            watch_running = 1'b1;
         end
         CMD_PAUSE: begin
            if (watch_running && !watch_frozen) begin
               watch_pause  = now;
               watch_frozen = 1'b1;
            end
         end
         CMD_RESUME: begin
            if (watch_running && watch_frozen) begin
               watch_paused += now - watch_pause;
               watch_pause  = '0;
               watch_frozen = 1'b0;
            end
         end
         CMD_SET: begin
            if (!watch_running) begin
               clear_watch();
               watch_start   = now;
               watch_running = 1'b1;
               watch_seek    = amount;
            end else begin
               watch_seek = amount;
               if (watch_frozen) begin
                  watch_pause = watch_start + watch_paused;
               end else begin
                  watch_start  = now;
                  watch_paused = '0;
               end
            end
         end
         CMD_SEEK_FWD: watch_seek += amount;
         CMD_SEEK_BACK: begin
            // Never seek back past zero elapsed time.
            e = watch_elapsed(now);
            watch_seek -= (e < amount) ? e : amount;
         end
         default: ;
      endcase

      e = watch_elapsed(now);
      r = '0;
      r.elapsed    = e;
      r.is_running = watch_running;
      r.is_frozen  = watch_frozen;
      // The before-start test wins when the window is inverted.
      if (e < ws) begin
         r.outside_distance = e - ws;
      end else if (e > we) begin
         r.outside_distance = e - we;
      end else begin
         r.in_window     = 1'b1;
         r.window_offset = e - ws;
      end
      return r;
   endfunction

   function automatic rsp_type hand_result(tick_type elapsed, logic running, logic frozen,
                                           logic in_win, tick_type offset,
                                           tick_type distance);
      rsp_type r;
      r                  = '0;
      r.elapsed          = elapsed;
      r.is_running       = running;
      r.is_frozen        = frozen;
      r.in_window        = in_win;
      r.window_offset    = offset;
      r.outside_distance = distance;
      return r;
   endfunction

   // Drives one command beat, holds it until taken, then records the reading.
   task automatic send_cmd(input cmd_row_type row);
      int      gap;
      rsp_type predicted;
      gap = 0;
      if (!calm && $urandom_range(99) < 30)
         gap = $urandom_range(1, 2);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.cmd;
      req_tdata  <= {row.win_end, row.win_start, row.amount, row.now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = advance_watch(row.cmd, row.now, row.amount, row.win_start, row.win_end);
      pending_readings.push_back(row.typed ? row.want : predicted);
      cmds_sent++;
   endtask

   // Holds off the sender until every outstanding reading has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
   endtask

   task automatic flag_mismatch(input string field, input logic [TICK_W-1:0] want,
                                input logic [TICK_W-1:0] got);
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      err_count++;
   endtask

   // Result checker and receiver stall pattern.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata);
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual %h", $time, rsp_tdata);
            err_count++;
         end else begin
            want = pending_readings.pop_front();
            if (got.elapsed !== want.elapsed)
               flag_mismatch("elapsed", want.elapsed, got.elapsed);
            if (got.is_running !== want.is_running)
               flag_mismatch("is_running", TICK_W'(want.is_running),
                             TICK_W'(got.is_running));
            if (got.is_frozen !== want.is_frozen)
               flag_mismatch("is_frozen", TICK_W'(want.is_frozen), TICK_W'(got.is_frozen));
            if (got.in_window !== want.in_window)
               flag_mismatch("in_window", TICK_W'(want.in_window), TICK_W'(got.in_window));
            if (got.window_offset !== want.window_offset)
               flag_mismatch("window_offset", want.window_offset, got.window_offset);
            if (got.outside_distance !== want.outside_distance)
               flag_mismatch("outside_distance", want.outside_distance,
                             got.outside_distance);
            results_checked++;
            if (want.in_window)
               window_hits++;
         end
      end

      // Mostly short random stalls, now and then a longer one.
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(199) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(8, 20);
      end else begin
         rsp_tready <= ($urandom_range(99) >= 28);
      end
   end

   // Watchdog: ends the run when no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, no beat moved for %0d cycles", $time, IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      cmd_row_type row;
      tick_type    ticks;
      tick_type    e;
      int          pick;

      clear_watch();
      // Directed commands: reset state, extremes, every command, corner cases.
      plan = '{
         '{CMD_QUERY,     64'd5,    64'd0,    64'd0,    64'd0,    1'b1,
           hand_result(64'd0, 1'b0, 1'b0, 1'b1, 64'd0, 64'd0)},
         '{CMD_SEEK_FWD,  64'd6,    64'd100,  64'd1,    64'd10,   1'b1,
           hand_result(64'd0, 1'b0, 1'b0, 1'b0, 64'd0, TICK_MAX)},
         '{CMD_PAUSE,     64'd7,    64'd0,    64'd0,    TICK_MAX, 1'b0, '0},
         '{CMD_RESUME,    64'd8,    64'd0,    64'd0,    TICK_MAX, 1'b0, '0},
         '{CMD_START,     64'd1000, 64'd0,    64'd0,    TICK_MAX, 1'b1,
           hand_result(64'd0, 1'b1, 1'b0, 1'b1, 64'd0, 64'd0)},
         '{CMD_SEEK_BACK, 64'd1010, TICK_MAX, 64'd0,    64'd0,    1'b0, '0},
         '{CMD_PAUSE,     64'd1020, 64'd0,    64'd5,    64'd3,    1'b0, '0},
         '{CMD_PAUSE,     64'd1030, 64'd0,    64'd0,    64'd100,  1'b0, '0},
         '{CMD_SET,       64'd1040, 64'd500,  64'd500,  64'd500,  1'b0, '0},
         '{CMD_RESUME,    64'd2000, 64'd0,    64'd0,    64'd100,  1'b0, '0},
         '{CMD_SET,       64'd2001, TICK_MAX, TICK_MAX, TICK_MAX, 1'b0, '0},
         '{CMD_SEEK_FWD,  64'd2001, 64'd1,    64'd0,    64'd0,    1'b0, '0},
         '{CMD_SEEK_BACK, 64'd2500, 64'd0,    64'd400,  64'd600,  1'b0, '0},
         '{CMD_SEEK_BACK, 64'd2600, 64'd50,   64'd0,    64'd10,   1'b0, '0},
         '{CMD_RESUME,    64'd2700, 64'd0,    64'd700,  64'd100,  1'b0, '0},
         '{CMD_QUERY,     TICK_MAX, TICK_MAX, 64'd0,    64'd0,    1'b0, '0},
         '{CMD_RESET,     64'd3000, 64'd0,    TICK_MAX, TICK_MAX, 1'b1,
           hand_result(64'd0, 1'b0, 1'b0, 1'b0, 64'd0, 64'd1)},
         '{CMD_SET,       TICK_MAX, 64'd7,    64'd7,    64'd7,    1'b0, '0},
         '{CMD_SEEK_BACK, 64'd5,    64'd3,    64'd0,    TICK_MAX, 1'b0, '0},
         '{CMD_START,     64'd0,    64'd0,    64'd0,    64'd0,    1'b0, '0},
         '{CMD_PAUSE,     TICK_MAX, 64'd0,    TICK_MAX, 64'd0,    1'b0, '0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_cmd(plan[i]);
      wait_drained();

      // Random command sequences along a tick stamp that mostly moves forward.
      ticks = TICK_W'($urandom_range(0, 100000));
      for (int n = 0; n < RAND_ITEMS; n++) begin
         calm = (n >= 600 && n < 850);
         if (n % 300 == 299)
            wait_drained();

         pick = $urandom_range(99);
         if (pick < 3)
            ticks = rand_tick();
         else if (pick < 5)
            ticks -= TICK_W'($urandom_range(1, 400));
         else
            ticks += TICK_W'($urandom_range(0, 500));

         row     = '0;
         row.now = ticks;
         pick    = $urandom_range(99);
         if (pick < 6)       row.cmd = CMD_RESET;
         else if (pick < 13) row.cmd = CMD_START;
         else if (pick < 29) row.cmd = CMD_PAUSE;
         else if (pick < 45) row.cmd = CMD_RESUME;
         else if (pick < 55) row.cmd = CMD_SET;
         else if (pick < 71) row.cmd = CMD_SEEK_FWD;
         else if (pick < 94) row.cmd = CMD_SEEK_BACK;
         else                row.cmd = CMD_QUERY;

         e    = watch_elapsed(ticks);
         pick = $urandom_range(99);
         if (pick < 50)      row.amount = TICK_W'($urandom_range(0, 2000));
         else if (pick < 62) row.amount = '0;
         else if (pick < 78) row.amount = e + TICK_W'($urandom_range(0, 20)) - 64'd10;
         else if (pick < 92) row.amount = rand_tick();
         else                row.amount = TICK_MAX - TICK_W'($urandom_range(0, 3));

         // Windows mostly sit around the current elapsed time.
         pick = $urandom_range(99);
         if (pick < 60) begin
            row.win_start = e - TICK_W'($urandom_range(0, 300));
            row.win_end   = e + TICK_W'($urandom_range(0, 300));
         end else if (pick < 72) begin
            row.win_start = e + TICK_W'($urandom_range(1, 300));
            row.win_end   = e - TICK_W'($urandom_range(0, 300));
         end else if (pick < 88) begin
            row.win_start = rand_tick();
            row.win_end   = rand_tick();
         end else if (pick < 94) begin
            row.win_start = '0;
            row.win_end   = TICK_MAX;
         end else begin
            row.win_start = e;
            row.win_end   = e;
         end
         send_cmd(row);
      end
      calm = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d commands driven (%0d directed, %0d random), %0d results checked",
               cmds_sent, DIR_ROWS, RAND_ITEMS, results_checked);
      $display("Summary: %0d results inside the event window, %0d mismatches",
               window_hits, err_count);
      if (err_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: pausable_seekable_stopwatch.f
src/psw_pkg.sv
src/psw_core.sv
src/psw_window.sv
src/pausable_seekable_stopwatch.sv
src/psw_checker.sv
sim/pausable_seekable_stopwatch_tb.sv
